// File: hw/rtl/ppe_pkg.sv
`timescale 1ns / 1ps

package ppe_pkg;

  localparam int unsigned PALETTE_DEPTH_DEF = 256;
  localparam int unsigned MAX_RUN_DEF       = 128;
  localparam int unsigned COLOR_W           = 16;
  localparam int unsigned INDEX_W           = 8;
  localparam int unsigned COUNT_W           = 8;

  localparam logic FUNC_PAL_WR = 1'b0;
  localparam logic FUNC_PIXEL  = 1'b1;

  typedef enum logic [1:0] {
    DEPTH_1BPP  = 2'd0,
    DEPTH_4BPP  = 2'd1,
    DEPTH_8BPP  = 2'd2,
    DEPTH_16BPP = 2'd3
  } ppe_depth_e;

  // one pixel handed from the sequencer to the output stage
  typedef struct packed {
    logic               valid;
    logic               pass;
    logic               zero;
    logic               last;
    logic [COLOR_W-1:0] word;
  } ppe_issue_t;

endpackage

// File: hw/rtl/palette_pixel_expander.sv
// Palette pixel expander: turns packed indexed pixel bytes into RGB565 pixels.
// Input channel (in_valid_i / in_stall_o) carries one transaction per item:
// func_i low writes palette_color_i into palette entry palette_index_i, func_i
// high delivers one source byte (or a native word at 16bpp) and, with
// run_start_i, opens a run of min(run_count_i, MAX_RUN) pixels at the given depth and offset.
// Output channel (out_valid_o / out_stall_i) delivers one pixel per
// transaction, last_pixel_o marking the pixel that completes the run.
// A data transaction that yields pixels (1 to 8) holds the input until the
// last of them is issued, one palette read issued each cycle from the single
// read port while the output stage accepts (none at 16bpp); palette writes and
// items that yield nothing do not hold the input.
// The first pixel passes the sequencer registers, the registered palette
// read, then the output register.
// While the receiver stalls, the output register and one pending read hold;
// the sequencer stops issuing and in_stall_o stays high until its byte is done.
// Reset clears the run state and the output stage; palette contents are not
// cleared and must be written before they are used.
`timescale 1ns / 1ps

module palette_pixel_expander import ppe_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_RUN       = MAX_RUN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [INDEX_W-1:0] palette_index_i,
  input  logic [COLOR_W-1:0] palette_color_i,
  input  logic [COLOR_W-1:0] pixel_data_i,
  input  logic               run_start_i,
  input  logic [COUNT_W-1:0] run_count_i,
  input  logic [1:0]         depth_code_i,
  input  logic [2:0]         start_offset_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_pixel_o
);

  localparam int unsigned IDX_W = $clog2(PALETTE_DEPTH);

  ppe_issue_t         issue;
  logic               issue_ok;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [COLOR_W-1:0] wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [COLOR_W-1:0] rd_data;

  ppe_seq #(
    .PALETTE_DEPTH (PALETTE_DEPTH),
    .MAX_RUN       (MAX_RUN)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .palette_index_i (palette_index_i),
    .palette_color_i (palette_color_i),
    .pixel_data_i    (pixel_data_i),
    .run_start_i     (run_start_i),
    .run_count_i     (run_count_i),
    .depth_code_i    (depth_code_i),
    .start_offset_i  (start_offset_i),
    .issue_ok_i      (issue_ok),
    .issue_o         (issue),
    .wr_en_o         (wr_en),
    .wr_addr_o       (wr_addr),
    .wr_data_o       (wr_data),
    .rd_en_o         (rd_en),
    .rd_addr_o       (rd_addr)
  );

  ppe_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  ppe_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .issue_i       (issue),
    .rd_data_i     (rd_data),
    .issue_ok_o    (issue_ok),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

// File: hw/rtl/ppe_ram.sv
`timescale 1ns / 1ps

module ppe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/ppe_seq.sv
`timescale 1ns / 1ps

module ppe_seq import ppe_pkg::*; #(
  parameter int unsigned PALETTE_DEPTH = PALETTE_DEPTH_DEF,
  parameter int unsigned MAX_RUN       = MAX_RUN_DEF,
  localparam int unsigned IDX_W        = $clog2(PALETTE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic [INDEX_W-1:0] palette_index_i,
  input  logic [COLOR_W-1:0] palette_color_i,
  input  logic [COLOR_W-1:0] pixel_data_i,
  input  logic               run_start_i,
  input  logic [COUNT_W-1:0] run_count_i,
  input  logic [1:0]         depth_code_i,
  input  logic [2:0]         start_offset_i,
  input  logic               issue_ok_i,
  output ppe_issue_t         issue_o,
  output logic               wr_en_o,
  output logic [IDX_W-1:0]   wr_addr_o,
  output logic [COLOR_W-1:0] wr_data_o,
  output logic               rd_en_o,
  output logic [IDX_W-1:0]   rd_addr_o
);

  localparam int unsigned LEFT_W = $clog2(MAX_RUN + 1);
  localparam int unsigned CMP_W  = (LEFT_W > COUNT_W) ? LEFT_W : COUNT_W;
  localparam logic [CMP_W-1:0]   MAX_RUN_C = CMP_W'(MAX_RUN);
  localparam logic [LEFT_W-1:0]  LEFT_ONE  = LEFT_W'(1);
  localparam logic [INDEX_W:0]   IDX_LIM   = (INDEX_W + 1)'(PALETTE_DEPTH);

  logic               busy_q, busy_d;
  logic [LEFT_W-1:0]  left_q, left_d;
  ppe_depth_e         mode_q, mode_d;
  logic [2:0]         pos_q, pos_d;
  logic [COLOR_W-1:0] word_q, word_d;

  logic               accept;
  logic               px_acc;
  logic               issue;
  logic               byte_done;
  logic [CMP_W-1:0]   count_ext;
  logic [LEFT_W-1:0]  count_sat;
  logic [7:0]         src_byte;
  logic [INDEX_W-1:0] idx;
  logic               in_range;
  logic               pass;

  assign accept     = in_valid_i && !busy_q;
  assign px_acc     = accept && (func_i == FUNC_PIXEL);
  assign in_stall_o = busy_q;

  assign wr_en_o   = accept && (func_i == FUNC_PAL_WR) &&
                     ({1'b0, palette_index_i} < IDX_LIM);
  assign wr_addr_o = palette_index_i[IDX_W-1:0];
  assign wr_data_o = palette_color_i;

  assign count_ext = CMP_W'(run_count_i);
  assign count_sat = (count_ext > MAX_RUN_C) ? LEFT_W'(MAX_RUN_C) : LEFT_W'(count_ext);

  assign src_byte = word_q[7:0];
  assign issue    = busy_q && issue_ok_i;
  assign pass     = (mode_q == DEPTH_16BPP);

  always_comb begin
    idx       = '0;
    byte_done = 1'b1;
    unique case (mode_q)
      DEPTH_1BPP: begin
        idx       = {{(INDEX_W-1){1'b0}}, src_byte[3'd7 - pos_q]};
        byte_done = (pos_q == 3'd7);
      end
      DEPTH_4BPP: begin
        idx       = pos_q[0] ? {4'b0, src_byte[3:0]} : {4'b0, src_byte[7:4]};
        byte_done = pos_q[0];
      end
      DEPTH_8BPP: begin
        idx = src_byte;
      end
      DEPTH_16BPP: begin
        idx = '0;
      end
      default: begin
        idx = '0;
      end
    endcase
  end

  assign in_range  = ({1'b0, idx} < IDX_LIM);
  assign rd_en_o   = issue && !pass && in_range;
  assign rd_addr_o = idx[IDX_W-1:0];

  always_comb begin
    issue_o.valid = issue;
    issue_o.pass  = pass;
    issue_o.zero  = !pass && !in_range;
    issue_o.last  = (left_q == LEFT_ONE);
    issue_o.word  = word_q;
  end

  always_comb begin
    busy_d = busy_q;
    left_d = left_q;
    mode_d = mode_q;
    pos_d  = pos_q;
    word_d = word_q;
    if (px_acc) begin
      word_d = pixel_data_i;
      if (run_start_i) begin
        left_d = count_sat;
        mode_d = ppe_depth_e'(depth_code_i);
        pos_d  = start_offset_i;
      end else begin
        pos_d = 3'd0;
      end
      busy_d = (left_d != '0);
    end else if (issue) begin
      left_d = left_q - LEFT_ONE;
      busy_d = !(byte_done || (left_q == LEFT_ONE));
      if (mode_q == DEPTH_4BPP) begin
        pos_d = 3'd1;
      end else begin
        pos_d = pos_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
      mode_q <= DEPTH_1BPP;
      pos_q  <= 3'd0;
    end else begin
      busy_q <= busy_d;
      left_q <= left_d;
      mode_q <= mode_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

endmodule

// File: hw/rtl/ppe_out.sv
`timescale 1ns / 1ps

module ppe_out import ppe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppe_issue_t         issue_i,
  input  logic [COLOR_W-1:0] rd_data_i,
  output logic               issue_ok_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [COLOR_W-1:0] pixel_color_o,
  output logic               last_pixel_o
);

  // pending stage lines up with the memory read data
  logic               pend_q, pend_d;
  logic               pend_pass_q;
  logic               pend_zero_q;
  logic               pend_last_q;
  logic [COLOR_W-1:0] pend_word_q;

  logic               out_valid_q, out_valid_d;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;

  logic               move;
  logic [COLOR_W-1:0] color_sel;

  assign move       = pend_q && (!out_valid_q || !out_stall_i);
  assign issue_ok_o = !pend_q || move;

  assign color_sel = pend_pass_q ? pend_word_q :
                     pend_zero_q ? '0 : rd_data_i;

  always_comb begin
    pend_d = pend_q;
    if (issue_i.valid) begin
      pend_d = 1'b1;
    end else if (move) begin
      pend_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (move) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i.valid) begin
      pend_pass_q <= issue_i.pass;
      pend_zero_q <= issue_i.zero;
      pend_last_q <= issue_i.last;
      pend_word_q <= issue_i.word;
    end
    if (move) begin
      color_q <= color_sel;
      last_q  <= pend_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = color_q;
  assign last_pixel_o  = last_q;

endmodule

// File: hw/rtl/ppe_checker.sv
`timescale 1ns / 1ps

module ppe_checker import ppe_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               func_i,
  input logic               run_start_i,
  input logic [COUNT_W-1:0] run_count_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [COLOR_W-1:0] pixel_color_o,
  input logic               last_pixel_o
);

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  // stalled output transaction stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transaction dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(pixel_color_o) && $stable(last_pixel_o))
    else $error("stalled output payload changed");

  // palette write never occupies the sequencer
  a_wr_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (func_i == FUNC_PAL_WR) |=> !in_stall_o)
    else $error("palette write blocked the input");

  // run opened with pixels keeps the input busy, empty run does not
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (func_i == FUNC_PIXEL) && run_start_i && (run_count_i != '0) |=> in_stall_o)
    else $error("run with pixels did not start the sequencer");

  a_run_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (func_i == FUNC_PIXEL) && run_start_i && (run_count_i == '0) |=> !in_stall_o)
    else $error("empty run started the sequencer");

endmodule

bind palette_pixel_expander ppe_checker u_ppe_checker (.*);

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ppe_pkg::*;

  typedef struct packed {
    logic               func;
    logic [INDEX_W-1:0] pidx;
    logic [COLOR_W-1:0] pcol;
    logic [COLOR_W-1:0] data;
    logic               start;
    logic [COUNT_W-1:0] count;
    ppe_depth_e         depth;
    logic [2:0]         offs;
  } ppe_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  typedef struct packed {
    ppe_item_t  it;
    logic       chk;
    logic [3:0] n;
    pixel_t     px;
  } dir_row_t;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic               func_i;
  logic [INDEX_W-1:0] palette_index_i;
  logic [COLOR_W-1:0] palette_color_i;
  logic [COLOR_W-1:0] pixel_data_i;
  logic               run_start_i;
  logic [COUNT_W-1:0] run_count_i;
  logic [1:0]         depth_code_i;
  logic [2:0]         start_offset_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [COLOR_W-1:0] pixel_color_o;
  logic               last_pixel_o;

  logic               rx_rand = 1'b0;
  logic               rx_hold = 1'b0;
  logic               drv_chk;
  logic [3:0]         drv_n;
  pixel_t             drv_px;

  int                 tx_idle_pct;
  int                 rx_idle_pct;
  int                 items_sent;
  int                 errors;
  int                 cycles;
  event               rx_hold_ev;

  // predictor state
  logic [COLOR_W-1:0] pal_model [256];
  logic [COUNT_W-1:0] run_left;
  ppe_depth_e         run_depth;
  logic [2:0]         run_pos;
  pixel_t             item_pixels [$];
  pixel_t             pending_pixels [$];

  // stimulus side: palette entries already written
  bit                 pal_written [256];

  dir_row_t dir_rows [22] = '{
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h5A5A, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'd1, DEPTH_16BPP, 3'd0},
      1'b1, 4'd1, '{16'hFFFF, 1'b1}},
    '{'{FUNC_PIXEL, 8'hFF, 16'hFFFF, 16'h0000, 1'b1, 8'd1, DEPTH_16BPP, 3'd7},
      1'b1, 4'd1, '{16'h0000, 1'b1}},
    '{'{FUNC_PAL_WR, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'hFF, DEPTH_16BPP, 3'd7},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PAL_WR, 8'h01, 16'hFFFF, 16'h0000, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PAL_WR, 8'hFF, 16'hA5C3, 16'h0000, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'hFFFF, 1'b1, 8'd1, DEPTH_8BPP, 3'd7},
      1'b1, 4'd1, '{16'hA5C3, 1'b1}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h00A5, 1'b1, 8'd8, DEPTH_1BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'hFF01, 1'b1, 8'd3, DEPTH_1BPP, 3'd7},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h0080, 1'b0, 8'hFF, DEPTH_16BPP, 3'd7},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'hFFFF, 1'b0, 8'd5, DEPTH_8BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h00FF, 1'b1, 8'd0, DEPTH_8BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PAL_WR, 8'h0F, 16'h1234, 16'h0000, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h00F0, 1'b1, 8'd3, DEPTH_4BPP, 3'd1},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h000F, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h10F1, 1'b1, 8'd5, DEPTH_4BPP, 3'd6},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h0001, 1'b1, 8'hFF, DEPTH_8BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h8001, 1'b1, 8'h81, DEPTH_16BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h8001, 1'b1, 8'd2, DEPTH_16BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'h7FFE, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b0, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PAL_WR, 8'h80, 16'h5555, 16'h0000, 1'b0, 8'd0, DEPTH_1BPP, 3'd0},
      1'b1, 4'd0, '{16'h0000, 1'b0}},
    '{'{FUNC_PIXEL, 8'h00, 16'h0000, 16'hFF80, 1'b1, 8'd1, DEPTH_8BPP, 3'd0},
      1'b1, 4'd1, '{16'h5555, 1'b1}}
  };

  assign out_stall_i = rx_rand | rx_hold;

  palette_pixel_expander dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("palette_pixel_expander test failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    rx_rand <= ($urandom_range(99) < rx_idle_pct);
  end

  // long receiver hold-off so that the block fills up
  always begin
    @(rx_hold_ev);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, msg);
  endtask

  function automatic void emit_pixel(logic [COLOR_W-1:0] c);
    run_left = run_left - 1'b1;
    item_pixels.push_back('{c, run_left == 0});
  endfunction

  function automatic void expand_item(ppe_item_t it);
    logic [7:0] b;
    int         p;
    b = it.data[7:0];
    item_pixels.delete();
    if (it.func == FUNC_PAL_WR) begin
      pal_model[it.pidx] = it.pcol;
      return;
    end
    if (it.start) begin
      run_left = (it.count > MAX_RUN_DEF) ? COUNT_W'(MAX_RUN_DEF) : it.count;
      run_depth = it.depth;
      run_pos = it.offs;
    end
    if (run_left == 0) return;
    case (run_depth)
      DEPTH_1BPP: begin
        for (p = run_pos; p < 8 && run_left != 0; p++) emit_pixel(pal_model[{7'd0, b[7-p]}]);
      end
      DEPTH_4BPP: begin
        if (!run_pos[0]) emit_pixel(pal_model[{4'd0, b[7:4]}]);
        if (run_left != 0) emit_pixel(pal_model[{4'd0, b[3:0]}]);
      end
      DEPTH_8BPP: emit_pixel(pal_model[b]);
      default: emit_pixel(it.data);
    endcase
    run_pos = 3'd0;
  endfunction

  always @(posedge clk_i) begin
    pixel_t    want;
    ppe_item_t seen;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %h last %b", pixel_color_o,
                                    last_pixel_o));
        end else begin
          want = pending_pixels.pop_front();
          if (pixel_color_o !== want.color)
            report_mismatch($sformatf("pixel_color %h, expected %h", pixel_color_o,
                                      want.color));
          if (last_pixel_o !== want.last)
            report_mismatch($sformatf("last_pixel %b, expected %b (pixel %h)",
                                      last_pixel_o, want.last, want.color));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        seen = '{func_i, palette_index_i, palette_color_i, pixel_data_i, run_start_i,
                 run_count_i, ppe_depth_e'(depth_code_i), start_offset_i};
        expand_item(seen);
        if (drv_chk) begin
          if (drv_n != 0) pending_pixels.push_back(drv_px);
        end else begin
          foreach (item_pixels[k]) pending_pixels.push_back(item_pixels[k]);
        end
      end
    end
  end

  function automatic ppe_item_t random_item(logic f);
    ppe_item_t it;
    it.func = f;
    it.pidx = INDEX_W'($urandom_range(255));
    it.pcol = COLOR_W'($urandom_range(16'hFFFF));
    it.data = COLOR_W'($urandom_range(16'hFFFF));
    it.start = 1'($urandom_range(1));
    it.count = COUNT_W'($urandom_range(255));
    it.depth = ppe_depth_e'($urandom_range(3));
    it.offs = 3'($urandom_range(7));
    return it;
  endfunction

  // called at a falling edge, returns at the falling edge after the transaction
  task automatic send_item(ppe_item_t it, logic chk, logic [3:0] n, pixel_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    func_i <= it.func;
    palette_index_i <= it.pidx;
    palette_color_i <= it.pcol;
    pixel_data_i <= it.data;
    run_start_i <= it.start;
    run_count_i <= it.count;
    depth_code_i <= it.depth;
    start_offset_i <= it.offs;
    drv_chk <= chk;
    drv_n <= n;
    drv_px <= px;
    in_valid_i <= 1'b1;
    if (it.func == FUNC_PAL_WR) pal_written[it.pidx] = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic fill_entry(logic [7:0] idx);
    ppe_item_t w;
    if (!pal_written[idx]) begin
      w = random_item(FUNC_PAL_WR);
      w.pidx = idx;
      send_item(w, 1'b0, 4'd0, '0);
      items_sent++;
    end
  endtask

  // write every palette entry the coming byte may read
  task automatic fill_for(ppe_item_t it, ppe_depth_e d);
    case (d)
      DEPTH_1BPP: begin
        fill_entry(8'd0);
        fill_entry(8'd1);
      end
      DEPTH_4BPP: begin
        fill_entry({4'd0, it.data[7:4]});
        fill_entry({4'd0, it.data[3:0]});
      end
      DEPTH_8BPP: fill_entry(it.data[7:0]);
      default: ;
    endcase
  endtask

  task automatic random_run();
    ppe_item_t  it;
    ppe_item_t  w;
    ppe_depth_e d;
    int         left;
    int         per;
    int         r;
    logic       first;
    it = random_item(FUNC_PIXEL);
    it.start = 1'b1;
    r = $urandom_range(99);
    if (r < 5) it.count = 8'd0;
    else if (r < 15) it.count = COUNT_W'($urandom_range(255));
    else it.count = COUNT_W'($urandom_range(1, 24));
    d = it.depth;
    left = (it.count > MAX_RUN_DEF) ? MAX_RUN_DEF : it.count;
    first = 1'b1;
    forever begin
      fill_for(it, d);
      send_item(it, 1'b0, 4'd0, '0);
      items_sent++;
      case (d)
        DEPTH_1BPP: per = first ? 8 - it.offs : 8;
        DEPTH_4BPP: per = first ? 2 - it.offs[0] : 2;
        default: per = 1;
      endcase
      left = (per >= left) ? 0 : left - per;
      first = 1'b0;
      if (left == 0) break;
      // run cut short by the next run start
      if ($urandom_range(29) == 0) return;
      if ($urandom_range(7) == 0) begin
        w = random_item(FUNC_PAL_WR);
        send_item(w, 1'b0, 4'd0, '0);
        items_sent++;
      end
      it = random_item(FUNC_PIXEL);
      it.start = 1'b0;
    end
    // data after the run is done
    if ($urandom_range(3) == 0) begin
      it = random_item(FUNC_PIXEL);
      it.start = 1'b0;
      send_item(it, 1'b0, 4'd0, '0);
      items_sent++;
    end
  endtask

  initial begin
    int   k;
    int   stage;
    logic paused;
    logic held;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = FUNC_PAL_WR;
    palette_index_i = '0;
    palette_color_i = '0;
    pixel_data_i = '0;
    run_start_i = 1'b0;
    run_count_i = '0;
    depth_code_i = DEPTH_1BPP;
    start_offset_i = '0;
    drv_chk = 1'b0;
    drv_n = '0;
    drv_px = '0;
    items_sent = 0;
    errors = 0;
    cycles = 0;
    paused = 1'b0;
    held = 1'b0;
    run_left = '0;
    run_depth = DEPTH_1BPP;
    run_pos = '0;
    tx_idle_pct = 22;
    rx_idle_pct = 85;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < 22; k++) begin
      send_item(dir_rows[k].it, dir_rows[k].chk, dir_rows[k].n, dir_rows[k].px);
      items_sent++;
    end

    for (stage = 0; stage < 3; stage++) begin
      case (stage)
        0: begin
          tx_idle_pct = 22;
          rx_idle_pct = 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct = 22;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      while (items_sent < 22 + (stage + 1) * 145) begin
        random_run();
        if (stage == 0 && !paused && items_sent > 90) begin
          wait_drained();
          paused = 1'b1;
        end
        if (stage == 2 && !held && items_sent > 350) begin
          -> rx_hold_ev;
          held = 1'b1;
        end
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("palette_pixel_expander test passed");
    end else begin
      $display("palette_pixel_expander test failed");
    end
    $finish;
  end

endmodule
